>>> rtl/tsl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsl_pkg
// shared types, constants and codes of the top-k score list
// ----------------------------------------------------------------------------
package tsl_pkg;

  localparam int unsigned LIST_DEPTH   = 10;
  localparam int unsigned NUM_CONTEXTS = 4;
  localparam int unsigned KEY_BITS     = 32;

  localparam int unsigned SCORE_W = 32;
  localparam int unsigned CTX_W   = 2;
  localparam int unsigned RANK_W  = 4;
  localparam int unsigned FKEY_W  = 32;

  // counters that can hold the depth itself
  localparam int unsigned CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int unsigned CSEL_W = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;

  // two banks per context, the list is rewritten into the other bank
  localparam int unsigned RAM_DEPTH = NUM_CONTEXTS * 2 * LIST_DEPTH;
  localparam int unsigned ADDR_W    = $clog2(RAM_DEPTH);

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [CTX_W-1:0]   context_req;
    logic [FKEY_W-1:0]  item_key;
    logic [SCORE_W-1:0] item_score;
  } in_word_t;

  typedef struct packed {
    logic [CTX_W-1:0]   out_context;
    logic [RANK_W-1:0]  rank;
    logic [FKEY_W-1:0]  entry_key;
    logic [SCORE_W-1:0] entry_score;
    logic               entry_valid;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [SCORE_W-1:0]  score;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic load;
    logic scan;
    logic decide;
    logic emit;
    logic clear;
  } dp_cmd_t;

  typedef struct packed {
    logic in_is_clear;
    logic in_ctx_ok;
    logic scan_done;
    logic drop;
    logic emit_done;
    logic clear_done;
  } dp_sts_t;

endpackage

>>> rtl/tsl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsl_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module tsl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/tsl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsl_ctrl
// sequencer of the top-k score list: accept, scan, decide, emit, clear
// ----------------------------------------------------------------------------
module tsl_ctrl
  import tsl_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_EMIT   = 5'b01000,
    ST_CLEAR  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load = in_valid_i;
        if (in_valid_i && sts_i.in_ctx_ok) begin
          state_d = sts_i.in_is_clear ? ST_CLEAR : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = sts_i.drop ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (sts_i.emit_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

>>> rtl/tsl_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsl_dpath
// list ram, per-context counts, scan and merge logic, output register
// ----------------------------------------------------------------------------
module tsl_dpath
  import tsl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  in_word_i,
  input  dp_cmd_t   cmd_i,
  output dp_sts_t   sts_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  function automatic logic [ADDR_W-1:0] addr_of(input logic [CSEL_W-1:0] csel,
                                                input logic              bank,
                                                input logic [CNT_W-1:0]  idx);
    int unsigned a;
    a = (int'(csel) * 2 + int'(bank)) * LIST_DEPTH + int'(idx);
    return ADDR_W'(a);
  endfunction

  // per-context state
  logic [CNT_W-1:0]        cnt_q [NUM_CONTEXTS];
  logic [NUM_CONTEXTS-1:0] bank_q;

  // request and walk state
  in_word_t            req_q;
  logic [CSEL_W-1:0]   csel_q;
  logic                rd_bank_q, rd_bank_d;
  logic [CNT_W-1:0]    n_q, n_d;
  logic [CNT_W-1:0]    n_new_q, n_new_d;
  logic [CNT_W-1:0]    r_q, r_d;
  logic [CNT_W-1:0]    j_q, j_d;
  logic                found_q, found_d;
  logic                ins_q, ins_d;
  logic [SCORE_W-1:0]  thr_q, thr_d;
  logic                out_valid_q, out_valid_d;
  out_word_t           out_word_q, out_word_d;

  logic [CSEL_W-1:0]   in_csel;
  logic [KEY_BITS-1:0] key;
  logic                out_free;
  logic [CNT_W-1:0]    r_nxt;
  logic                have_old, skip, take_new, is_last, step_go, emit_go;
  logic                commit, clear_go;

  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  entry_t              ram_wdata, old;

  tsl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (old)
  );

  assign in_csel  = CSEL_W'(in_word_i.context_req);
  assign key      = KEY_BITS'(req_q.item_key);
  assign out_free = !out_valid_q || out_ready_i;
  assign r_nxt    = r_q + CNT_W'(1);

  // merge step: skip the old copy of the key, put the new entry ahead of
  // the first strictly lower score
  assign have_old = (r_q < n_q);
  assign skip     = have_old && (old.key == key);
  assign take_new = !skip && !ins_q && (!have_old || (old.score < req_q.item_score));
  assign is_last  = ((j_q + CNT_W'(1)) == n_new_q);
  assign step_go  = cmd_i.emit && out_free;
  assign emit_go  = step_go && !skip;
  assign commit   = emit_go && is_last;
  assign clear_go = cmd_i.clear && out_free;

  always_comb begin
    rd_bank_d   = rd_bank_q;
    n_d         = n_q;
    n_new_d     = n_new_q;
    r_d         = r_q;
    j_d         = j_q;
    found_d     = found_q;
    ins_d       = ins_q;
    thr_d       = thr_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    ram_re      = 1'b0;
    ram_raddr   = addr_of(csel_q, rd_bank_q, r_q);
    ram_we      = 1'b0;
    ram_waddr   = addr_of(csel_q, ~rd_bank_q, j_q);
    ram_wdata   = take_new ? entry_t'{key, req_q.item_score} : old;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.load) begin
      n_d       = cnt_q[in_csel];
      rd_bank_d = bank_q[in_csel];
      r_d       = '0;
      found_d   = 1'b0;
      thr_d     = '0;
    end

    if (cmd_i.scan) begin
      // data of entry r-1 arrives the cycle after its read
      if (r_q != '0) begin
        found_d = found_q | (old.key == key);
        thr_d   = old.score;
      end
      if (r_q < n_q) begin
        ram_re = 1'b1;
        r_d    = r_nxt;
      end
    end

    if (cmd_i.decide) begin
      r_d     = '0;
      j_d     = '0;
      ins_d   = 1'b0;
      n_new_d = (found_q || (n_q == CNT_W'(LIST_DEPTH))) ? n_q : (n_q + CNT_W'(1));
      ram_re  = (n_q != '0);
      ram_raddr = addr_of(csel_q, rd_bank_q, '0);
    end

    if (step_go) begin
      if (!take_new) begin
        r_d       = r_nxt;
        ram_re    = (r_nxt < n_q);
        ram_raddr = addr_of(csel_q, rd_bank_q, r_nxt);
      end
      if (!skip) begin
        ram_we      = 1'b1;
        j_d         = j_q + CNT_W'(1);
        ins_d       = ins_q | take_new;
        out_valid_d = 1'b1;
        out_word_d.out_context = req_q.context_req;
        out_word_d.rank        = RANK_W'(j_q);
        out_word_d.entry_key   = take_new ? FKEY_W'(key) : FKEY_W'(old.key);
        out_word_d.entry_score = take_new ? req_q.item_score : old.score;
        out_word_d.entry_valid = 1'b1;
        out_word_d.last        = is_last;
      end
    end

    if (clear_go) begin
      out_valid_d = 1'b1;
      out_word_d  = '0;
      out_word_d.out_context = req_q.context_req;
      out_word_d.last        = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CONTEXTS; c++) begin
        cnt_q[c] <= '0;
      end
      bank_q      <= '0;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      n_new_q     <= '0;
      r_q         <= '0;
      j_q         <= '0;
      found_q     <= 1'b0;
      ins_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      n_q         <= n_d;
      n_new_q     <= n_new_d;
      r_q         <= r_d;
      j_q         <= j_d;
      found_q     <= found_d;
      ins_q       <= ins_d;
      if (commit) begin
        cnt_q[csel_q]  <= n_new_q;
        bank_q[csel_q] <= ~rd_bank_q;
      end else if (clear_go) begin
        cnt_q[csel_q] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= in_word_i;
      csel_q <= in_csel;
    end
    rd_bank_q  <= rd_bank_d;
    thr_q      <= thr_d;
    out_word_q <= out_word_d;
  end

  assign sts_o.in_is_clear = (in_word_i.opcode == OP_CLEAR);
  assign sts_o.in_ctx_ok   = (32'(in_word_i.context_req) < NUM_CONTEXTS);
  assign sts_o.scan_done   = (r_q >= n_q);
  assign sts_o.drop        = (n_q == CNT_W'(LIST_DEPTH)) ? (req_q.item_score <= thr_q)
                                                         : (req_q.item_score == '0);
  assign sts_o.emit_done   = commit;
  assign sts_o.clear_done  = clear_go;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

>>> rtl/topk_score_list_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// topk_score_list_core
// per-context top-k list of key/score entries, kept in descending score order
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_ready_o / in_word_i) takes one word per
//   request: a score update or a clear of one context's list
//   output channel (out_valid_o / out_ready_i / out_word_o) gives the list
//   in rank order, one entry per word, last set on the final word
//   an update at or below the threshold of a full list, or with a zero score, gives no output word
// request handling
//   one request is handled at a time; in_ready_o is high only when idle
//   an update is accepted, its list is scanned for the key and the threshold,
//     a decide step drops it or starts the merge walk, which emits each entry
//     of the new list and passes over the old copy of a listed key; a clear
//     gives its single word; the single read port of the list ram is walked
//     once to find the key and the threshold and once to merge
// reset and stalls
//   reset empties every list through the per-context counts; the ram needs
//   no clearing pass, entries past a count are never read
//   a stalled receiver holds the output register and halts the merge walk
// ----------------------------------------------------------------------------
module topk_score_list_core
  import tsl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  // command and status between sequencer and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  tsl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // list ram lives in the datapath, two banks per context
  tsl_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  // the final word of a report returns the block to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sts.emit_done || sts.clear_done) |=> in_ready_o)
    else $error("block not idle after final word");

  // a word on a valid context starts work
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && sts.in_ctx_ok) |=> !in_ready_o)
    else $error("accepted word did not start work");

  // no output word is produced while idle
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !(sts.emit_done || sts.clear_done || cmd.emit))
    else $error("output activity while idle");

  // an empty report is a single word
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.entry_valid) |-> out_word_o.last)
    else $error("empty report word without last");

endmodule
